>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// types and constants of the integer to ascii formatter
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int VALUE_W     = 64;
    localparam int DIGIT_COUNT = 20;
    localparam int DIGITS_W    = 4 * DIGIT_COUNT;
    localparam int LEN_W       = 5;

    // format modes
    localparam logic [1:0] OP_SDEC = 2'd0;
    localparam logic [1:0] OP_UDEC = 2'd1;
    localparam logic [1:0] OP_HEX  = 2'd2;
    localparam logic [1:0] OP_PTR  = 2'd3;

    // ascii codes
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_X     = 7'h78;
    localparam logic [6:0] CH_ALPHA = 7'h37;

    typedef struct packed {
        logic [VALUE_W-1:0] mag;
        logic               neg;
        logic               hex;
        logic               ptr;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_LEAD,
        S_SIGN,
        S_PFX0,
        S_PFXX,
        S_DIGIT
    } t_state;

    function automatic logic [6:0] hex_glyph(input logic [3:0] d);
        logic [6:0] g;
        if (d < 4'd10) begin
            g = CH_ZERO + {3'd0, d};
        end else begin
            g = CH_ALPHA + {3'd0, d};
        end
        return g;
    endfunction

endpackage

>>> src/itoa_front.sv
// ----------------------------------------------------------------------------
// itoa_front
// classifies an item: picks radix, sign and magnitude
// ----------------------------------------------------------------------------
module itoa_front (
    input  logic [63:0]        i_value,
    input  logic [1:0]         i_operation,
    output itoa_pkg::t_job     o_job
);
    import itoa_pkg::*;

    logic [32:0] neg_mag;

    // magnitude of a negative 32-bit value, formed wide so the minimum fits
    assign neg_mag = 33'h1_0000_0000 - {1'b0, i_value[31:0]};

    always_comb begin
        o_job = '0;
        case (i_operation)
            OP_SDEC: begin
                o_job.neg = i_value[31];
                if (i_value[31]) begin
                    o_job.mag = {31'd0, neg_mag};
                end else begin
                    o_job.mag = {32'd0, i_value[31:0]};
                end
            end
            OP_UDEC: begin
                o_job.mag = i_value;
            end
            OP_HEX: begin
                o_job.mag = {32'd0, i_value[31:0]};
                o_job.hex = 1'b1;
            end
            OP_PTR: begin
                o_job.mag = i_value;
                o_job.ptr = 1'b1;
            end
            default: begin
                o_job = '0;
            end
        endcase
    end

endmodule

>>> src/itoa_queue.sv
// ----------------------------------------------------------------------------
// itoa_queue
// two-entry queue of classified items between front and back
// ----------------------------------------------------------------------------
module itoa_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push_valid,
    output logic               o_push_ready,
    input  itoa_pkg::t_job     i_job,
    output logic               o_pop_valid,
    input  logic               i_pop_ready,
    output itoa_pkg::t_job     o_job
);
    import itoa_pkg::*;

    t_job       r_head, n_head;
    t_job       r_tail, n_tail;
    logic [1:0] r_count, n_count;
    logic       push, pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_job        = r_head;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        case (r_count)
            2'd0: begin
                if (push) begin
                    n_head  = i_job;
                    n_count = 2'd1;
                end
            end
            2'd1: begin
                if (push && pop) begin
                    n_head = i_job;
                end else if (push) begin
                    n_tail  = i_job;
                    n_count = 2'd2;
                end else if (pop) begin
                    n_count = 2'd0;
                end
            end
            2'd2: begin
                if (pop) begin
                    n_head  = r_tail;
                    n_count = 2'd1;
                end
            end
            default: begin
                n_count = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
    end

endmodule

>>> src/itoa_back.sv
// ----------------------------------------------------------------------------
// itoa_back
// digit extraction and character sequencing with an output register
// ----------------------------------------------------------------------------
module itoa_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    output logic               o_job_ready,
    input  itoa_pkg::t_job     i_job,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [6:0]         o_character,
    output logic               o_last
);
    import itoa_pkg::*;

    t_state                r_state, n_state;
    logic [DIGITS_W-1:0]   r_digits, n_digits;
    logic [VALUE_W-1:0]    r_bin, n_bin;
    logic                  r_neg, n_neg;
    logic [3:0]            r_step, n_step;
    logic [LEN_W-1:0]      r_len, n_len;
    logic                  r_out_valid, n_out_valid;
    logic [6:0]            r_char, n_char;
    logic                  r_last, n_last;

    logic                  out_ok;
    logic [DIGITS_W-1:0]   dab_digits;
    logic [VALUE_W-1:0]    dab_bin;
    logic [LEN_W-1:0]      lead_len;
    logic [3:0]            cur_digit;

    assign out_ok      = !r_out_valid || i_ready;
    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;
    assign cur_digit   = r_digits[{r_len - 5'd1, 2'b00} +: 4];

    // shift-add-3 conversion, four bits per cycle
    always_comb begin
        dab_digits = r_digits;
        dab_bin    = r_bin;
        for (int s = 0; s < 4; s++) begin
            for (int k = 0; k < DIGIT_COUNT; k++) begin
                if (dab_digits[4*k +: 4] >= 4'd5) begin
                    dab_digits[4*k +: 4] = dab_digits[4*k +: 4] + 4'd3;
                end
            end
            dab_digits = {dab_digits[DIGITS_W-2:0], dab_bin[VALUE_W-1]};
            dab_bin    = {dab_bin[VALUE_W-2:0], 1'b0};
        end
    end

    // count of significant digits, at least one
    always_comb begin
        lead_len = 5'd1;
        for (int k = 0; k < DIGIT_COUNT; k++) begin
            if (r_digits[4*k +: 4] != 4'd0) begin
                lead_len = LEN_W'(k + 1);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_digits    = r_digits;
        n_bin       = r_bin;
        n_neg       = r_neg;
        n_step      = r_step;
        n_len       = r_len;
        n_out_valid = r_out_valid && !i_ready;
        n_char      = r_char;
        n_last      = r_last;
        o_job_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job_valid) begin
                    n_bin  = i_job.mag;
                    n_neg  = i_job.neg;
                    n_step = 4'd0;
                    if (i_job.ptr) begin
                        n_digits = {16'd0, i_job.mag};
                        n_len    = 5'd16;
                        n_state  = S_PFX0;
                    end else if (i_job.hex) begin
                        n_digits = {16'd0, i_job.mag};
                        n_state  = S_LEAD;
                    end else begin
                        n_digits = '0;
                        n_state  = S_CONV;
                    end
                end
            end
            S_CONV: begin
                n_digits = dab_digits;
                n_bin    = dab_bin;
                n_step   = r_step + 4'd1;
                if (r_step == 4'd15) begin
                    n_state = S_LEAD;
                end
            end
            S_LEAD: begin
                n_len   = lead_len;
                n_state = r_neg ? S_SIGN : S_DIGIT;
            end
            S_SIGN: begin
                if (out_ok) begin
                    n_out_valid = 1'b1;
                    n_char      = CH_MINUS;
                    n_last      = 1'b0;
                    n_state     = S_DIGIT;
                end
            end
            S_PFX0: begin
                if (out_ok) begin
                    n_out_valid = 1'b1;
                    n_char      = CH_ZERO;
                    n_last      = 1'b0;
                    n_state     = S_PFXX;
                end
            end
            S_PFXX: begin
                if (out_ok) begin
                    n_out_valid = 1'b1;
                    n_char      = CH_X;
                    n_last      = 1'b0;
                    n_state     = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (out_ok) begin
                    n_out_valid = 1'b1;
                    n_char      = hex_glyph(cur_digit);
                    n_last      = (r_len == 5'd1);
                    n_len       = r_len - 5'd1;
                    if (r_len == 5'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digits <= n_digits;
        r_bin    <= n_bin;
        r_neg    <= n_neg;
        r_step   <= n_step;
        r_len    <= n_len;
        r_char   <= n_char;
        r_last   <= n_last;
    end

endmodule

>>> src/integer_to_ascii_formatter_unit.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// formats a 64-bit value as ascii text, one character per output item
// ----------------------------------------------------------------------------
// input channel: i_valid / o_ready with i_value and i_operation (signed
// decimal, unsigned decimal, hex, pointer). output channel: o_valid /
// i_ready with o_character and o_last, last set on the final character.
// an item is classified on entry and parked in a two-entry queue, so up to
// two items are taken while the back end is still busy.
// back end steps: it picks up the item from the queue, then
//   decimal: shift-add-3 conversion (four bits a cycle), a leading-digit
//            step, a minus sign if negative, then the digits
//   hex:     a leading-digit step, then up to 8 characters
//   pointer: 18 characters
// characters go out one per cycle while the receiver is ready. the digit
// converter and the character output set the rate; the back end takes no
// new item before its last character. a stalled receiver holds the output
// register and the back end waits; the queue keeps taking items until it
// is full. reset empties the queue and output register, idles the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_to_ascii_formatter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_value,
    input  logic [1:0]  i_operation,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_character,
    output logic        o_last
);
    import itoa_pkg::*;

    t_job front_job;
    t_job queue_job;
    logic q_valid;
    logic q_ready;

    itoa_front u_front (
        .i_value     (i_value),
        .i_operation (i_operation),
        .o_job       (front_job)
    );

    itoa_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (i_valid),
        .o_push_ready (o_ready),
        .i_job        (front_job),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_job        (queue_job)
    );

    itoa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_ready (q_ready),
        .i_job       (queue_job),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

    // a full queue always has work for the back end
    `ASSERT_IMPLIES(a_full_has_work, i_clk, i_rst_n, !o_ready, q_valid)

    // the text always ends in a digit
    `ASSERT_IMPLIES(a_last_is_digit, i_clk, i_rst_n, o_valid && o_last, ((o_character >= CH_ZERO) && (o_character <= 7'h39)) || ((o_character >= 7'h41) && (o_character <= 7'h46)))

    // a sign is always followed by digits
    `ASSERT_IMPLIES(a_sign_not_last, i_clk, i_rst_n, o_valid && (o_character == CH_MINUS), !o_last)

endmodule

>>> sim/itoa_text_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// itoa_text_checker
// watches both channels of the integer to ascii formatter and checks its text
// ----------------------------------------------------------------------------
// every item taken on the input channel is turned into the characters it
// should produce, queued in order. every character taken on the output
// channel is compared with the oldest queued one, character and last flag
// separately. mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module itoa_text_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_value,
    input  logic [1:0]  i_operation,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [6:0]  i_character,
    input  logic        i_last,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_checked,
    output int          o_texts
);
    import itoa_pkg::*;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } t_char_due;

    localparam logic [127:0] HEX_DIGITS   = "0123456789ABCDEF";
    localparam int           REPORT_LINES = 32;

    t_char_due chars_due [$];
    int        mismatches = 0;
    int        pending    = 0;
    int        checked    = 0;
    int        texts      = 0;

    assign o_mismatches = mismatches;
    assign o_pending    = pending;
    assign o_checked    = checked;
    assign o_texts      = texts;

    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        c = HEX_DIGITS[8 * (15 - int'(d)) +: 8];
        return c[6:0];
    endfunction

    function automatic void push_char(input logic [6:0] ch);
        t_char_due c;
        c.ch   = ch;
        c.last = 1'b0;
        chars_due.push_back(c);
    endfunction

    // digits of mag, most significant first, no leading zeros
    function automatic void push_digits(input logic [63:0] mag, input logic [63:0] radix);
        logic [6:0] rev [DIGIT_COUNT];
        int         n;
        n = 0;
        do begin
            rev[n] = digit_char(4'(mag % radix));
            n++;
            mag = mag / radix;
        end while (mag != 64'd0 && n < DIGIT_COUNT);
        while (n > 0) begin
            n--;
            push_char(rev[n]);
        end
    endfunction

    function automatic void predict_text(input logic [63:0] value, input logic [1:0] op);
        logic [31:0] low;
        t_char_due   tail;
        int          i;
        low = value[31:0];
        case (op)
            OP_SDEC: begin
                if (low[31]) begin
                    push_char(CH_MINUS);
                    push_digits(64'h1_0000_0000 - {32'd0, low}, 64'd10);
                end else begin
                    push_digits({32'd0, low}, 64'd10);
                end
            end
            OP_UDEC: begin
                push_digits(value, 64'd10);
            end
            OP_HEX: begin
                push_digits({32'd0, low}, 64'd16);
            end
            default: begin
                push_char(CH_ZERO);
                push_char(CH_X);
                for (i = 15; i >= 0; i--) begin
                    push_char(digit_char(value[4 * i +: 4]));
                end
            end
        endcase
        tail = chars_due.pop_back();
        tail.last = 1'b1;
        chars_due.push_back(tail);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < REPORT_LINES) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin : watch
        t_char_due due;
        if (!i_rst_n) begin
            chars_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (chars_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                              i_character, i_last));
                end else begin
                    due = chars_due.pop_front();
                    if (i_character !== due.ch) begin
                        report_mismatch($sformatf("text %0d char %0d: got 0x%02h want 0x%02h",
                                                  texts, checked, i_character, due.ch));
                    end
                    if (i_last !== due.last) begin
                        report_mismatch($sformatf("text %0d char %0d: last %0b want %0b",
                                                  texts, checked, i_last, due.last));
                    end
                    checked++;
                    if (due.last) begin
                        texts++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_text(i_value, i_operation);
            end
        end
        pending = chars_due.size();
    end

endmodule

>>> sim/tb_integer_to_ascii_formatter_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter_unit
// stimulus and verdict for the integer to ascii formatter
// ----------------------------------------------------------------------------
// drives a directed set of edge values in all four format modes, then a
// random mix of values of every magnitude. both channels idle at random,
// with quiet stretches and one full drain. the checker beside the block
// predicts every character and counts mismatches.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter_unit;
    import itoa_pkg::*;

    localparam int RANDOM_ITEMS = 220;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [63:0] i_value;
    logic [1:0]  i_operation;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [6:0]  o_character;
    logic        o_last;

    int mismatches;
    int pending;
    int checked;
    int texts;

    int gap_pct   = 0;
    int stall_pct = 0;
    int rx_hold   = 0;
    int sent_per_op [4] = '{0, 0, 0, 0};

    integer_to_ascii_formatter_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .i_operation (i_operation),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

    itoa_text_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_value      (i_value),
        .i_operation  (i_operation),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_character  (o_character),
        .i_last       (o_last),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_texts      (texts)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #40_000_000;
        $display("timeout with %0d characters outstanding", pending);
        $display("CHECK FAILED");
        $finish;
    end

    // mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(7) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if ($urandom_range(99) < stall_pct) begin
            i_ready <= 1'b0;
            rx_hold <= idle_len() - 1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // called and returns at a falling edge
    task automatic send_item(input logic [63:0] v, input logic [1:0] op);
        int gap;
        gap = ($urandom_range(99) < gap_pct) ? idle_len() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_value     <= v;
        i_operation <= op;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent_per_op[op]++;
        @(negedge i_clk);
    endtask

    // values of every digit count, with weight on decimal boundaries
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        logic [63:0] p;
        int          k;
        case ($urandom_range(5))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 1000));
            2: v = {32'($urandom), 32'($urandom)} >> $urandom_range(63);
            3: v = {$urandom, $urandom} | 64'hFFFF_FFFF_8000_0000;
            4: begin
                p = 64'd1;
                k = $urandom_range(1, 19);
                repeat (k) p = p * 64'd10;
                v = p + 64'($urandom_range(2)) - 64'd1;
            end
            default: v = {32'($urandom), 32'd0} | 64'($urandom_range(0, 99999));
        endcase
        return v;
    endfunction

    initial begin
        int i;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_value     = 64'd0;
        i_operation = OP_SDEC;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        gap_pct   = 20;
        stall_pct = 20;
        // signed decimal: zero, extremes, most negative, ignored high bits
        send_item(64'd0, OP_SDEC);
        send_item(64'd1, OP_SDEC);
        send_item(64'h0000_0000_7FFF_FFFF, OP_SDEC);
        send_item(64'h0000_0000_8000_0000, OP_SDEC);
        send_item(64'h0000_0000_FFFF_FFFF, OP_SDEC);
        send_item(64'hFFFF_FFFF_0000_0005, OP_SDEC);
        send_item(64'h1234_5678_FFFF_FF85, OP_SDEC);
        // unsigned decimal: longest text and no sign extension
        send_item(64'd0, OP_UDEC);
        send_item(64'd9, OP_UDEC);
        send_item(64'd10, OP_UDEC);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, OP_UDEC);
        send_item(64'h0000_0000_FFFF_FFFF, OP_UDEC);
        send_item(64'h8000_0000_0000_0000, OP_UDEC);
        send_item(64'd10000000000000000000, OP_UDEC);
        // hex: no leading zeros, high half dropped
        send_item(64'd0, OP_HEX);
        send_item(64'h0000_0000_0000_000F, OP_HEX);
        send_item(64'h0000_0000_FFFF_FFFF, OP_HEX);
        send_item(64'hDEAD_BEEF_ABCD_EF01, OP_HEX);
        send_item(64'hFFFF_FFFF_8000_0000, OP_HEX);
        // pointer: always sixteen digits
        send_item(64'd0, OP_PTR);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, OP_PTR);
        send_item(64'h0123_4567_89AB_CDEF, OP_PTR);

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(2))
                    0: begin
                        gap_pct   = 0;
                        stall_pct = 0;
                    end
                    1: begin
                        gap_pct   = 50;
                        stall_pct = 50;
                    end
                    default: begin
                        gap_pct   = 15;
                        stall_pct = 20;
                    end
                endcase
            end
            if (i == RANDOM_ITEMS / 2) begin
                // let the block empty completely before going on
                i_valid <= 1'b0;
                while (pending != 0) @(negedge i_clk);
                @(negedge i_clk);
            end
            send_item(random_value(), 2'($urandom_range(3)));
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        $display("sent %0d values: signed %0d, unsigned %0d, hex %0d, pointer %0d",
                 sent_per_op[0] + sent_per_op[1] + sent_per_op[2] + sent_per_op[3],
                 sent_per_op[0], sent_per_op[1], sent_per_op[2], sent_per_op[3]);
        $display("compared %0d characters in %0d texts, %0d mismatches",
                 checked, texts, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
